@@ src/tes_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths and helper functions for the tetrahedron stiffness block.
// Used by every module under src; depends on nothing.
package tes_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int IN_W     = 32;
  localparam int N_IN     = 12;
  localparam int EW       = IN_W + 1;
  localparam int N_EDGE   = 9;
  localparam int OPW      = 70;
  localparam int LIMB_W   = OPW / 2;
  localparam int PW       = 2 * OPW;
  localparam int ACCW     = PW + 2;
  localparam int NW       = ACCW - 1;
  localparam int DW       = NW + 3;
  localparam int QW       = 47;
  localparam int REMW     = DW + QW;
  localparam int VW       = 48;
  localparam int LW       = 47;
  localparam int RF_DEPTH = 21;
  localparam int RF_AW    = $clog2(RF_DEPTH);
  localparam int Q_DEPTH  = 2;
  localparam int IN_TDATA_W  = N_IN * IN_W;
  localparam int OUT_TDATA_W = 104;

  typedef logic [N_EDGE*EW-1:0] edges_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_LOAD, BK_RD, BK_MS, BK_MW, BK_DST, BK_DWT, BK_EMIT
  } bk_state_t;

  typedef enum logic [1:0] {PH_CROSS, PH_G1, PH_DET, PH_ENT} ph_t;

  typedef struct packed {
    logic           start;
    logic [OPW-1:0] a;
    logic [OPW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic          done;
    logic [PW-1:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic          start;
    logic [NW-1:0] n;
    logic [DW-1:0] d;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic          sat;
    logic [QW-1:0] q;
  } div_rsp_t;

  // Operand file layout: edges e[v][a] first, then gradients g[k][a].
  function automatic logic [RF_AW-1:0] e_addr(input logic [1:0] v, input logic [1:0] a);
    return RF_AW'(3 * int'(v) + int'(a));
  endfunction

  function automatic logic [RF_AW-1:0] g_addr(input logic [1:0] k, input logic [1:0] a);
    return RF_AW'(N_EDGE + 3 * int'(k) + int'(a));
  endfunction

endpackage

@@ src/tes_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts vertex requests and forms the edge vectors from the first vertex to each of the other vertices.
// Depends on tes_pkg; feeds tes_queue.
module tes_front (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tes_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                           q_full,
  output logic                           q_push,
  output tes_pkg::edges_t                q_wdata
);

  logic [tes_pkg::IN_W-1:0] base;
  logic [tes_pkg::IN_W-1:0] vert;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_wdata = '0;
    base    = '0;
    vert    = '0;
    for (int v = 0; v < 3; v++) begin
      for (int a = 0; a < 3; a++) begin
        base = in_tdata[a*tes_pkg::IN_W +: tes_pkg::IN_W];
        vert = in_tdata[((v+1)*3+a)*tes_pkg::IN_W +: tes_pkg::IN_W];
        q_wdata[(v*3+a)*tes_pkg::EW +: tes_pkg::EW] =
          {vert[tes_pkg::IN_W-1], vert} - {base[tes_pkg::IN_W-1], base};
      end
    end
  end

endmodule

@@ src/tes_queue.sv @@
`timescale 1ns / 1ps
// Short queue of edge sets between the front end and the compute engine.
// Depends on tes_pkg.
module tes_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tes_pkg::edges_t wdata,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output tes_pkg::edges_t rdata
);

  localparam int QA = $clog2(tes_pkg::Q_DEPTH);

  tes_pkg::edges_t  mem_r [tes_pkg::Q_DEPTH];
  logic [QA-1:0]    wptr_r;
  logic [QA-1:0]    rptr_r;
  logic [QA:0]      cnt_r;

  assign full  = (cnt_r == (QA+1)'(tes_pkg::Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        mem_r[wptr_r] <= wdata;
        wptr_r        <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ src/tes_mul.sv @@
`timescale 1ns / 1ps
// Signed 70 x 70 multiplier built from four 35 x 35 partial products.
// Depends on tes_pkg; used by tes_back.
module tes_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  tes_pkg::mul_req_t req,
  output tes_pkg::mul_rsp_t rsp
);

  localparam int L = tes_pkg::LIMB_W;

  logic                      busy_r;
  logic                      post_r;
  logic                      done_r;
  logic [2:0]                cnt_r;
  logic                      sign_r;
  logic [tes_pkg::OPW-1:0]   ma_r;
  logic [tes_pkg::OPW-1:0]   mb_r;
  logic [2*L-1:0]            pp_r;
  logic [tes_pkg::PW-1:0]    sum_r;
  logic [tes_pkg::PW-1:0]    prod_r;
  logic [L-1:0]              la;
  logic [L-1:0]              lb;
  logic [tes_pkg::PW-1:0]    pp_sh;
  logic [tes_pkg::OPW-1:0]   abs_a;
  logic [tes_pkg::OPW-1:0]   abs_b;

  assign abs_a = req.a[tes_pkg::OPW-1] ? (~req.a + 1'b1) : req.a;
  assign abs_b = req.b[tes_pkg::OPW-1] ? (~req.b + 1'b1) : req.b;

  assign la = cnt_r[1] ? ma_r[2*L-1:L] : ma_r[L-1:0];
  assign lb = cnt_r[2] ? mb_r[2*L-1:L] : mb_r[L-1:0];

  always_comb begin
    case (cnt_r[2:1])
      2'd0:    pp_sh = tes_pkg::PW'(pp_r);
      2'd3:    pp_sh = tes_pkg::PW'(pp_r) << (2*L);
      default: pp_sh = tes_pkg::PW'(pp_r) << L;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.p    = prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      post_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        sum_r  <= '0;
        sign_r <= req.a[tes_pkg::OPW-1] ^ req.b[tes_pkg::OPW-1];
        ma_r   <= abs_a;
        mb_r   <= abs_b;
      end else if (busy_r) begin
        // Even steps form a partial product, odd steps fold it into the sum.
        if (!cnt_r[0]) begin
          pp_r <= la * lb;
        end else begin
          sum_r <= sum_r + pp_sh;
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 3'd7) begin
          busy_r <= 1'b0;
          post_r <= 1'b1;
        end
      end else if (post_r) begin
        post_r <= 1'b0;
        done_r <= 1'b1;
        prod_r <= sign_r ? (~sum_r + 1'b1) : sum_r;
      end
    end
  end

endmodule

@@ src/tes_div.sv @@
`timescale 1ns / 1ps
// Restoring divider with a 47-bit quotient and an overflow flag, one bit per cycle.
// Depends on tes_pkg; used by tes_back.
module tes_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tes_pkg::div_req_t req,
  output tes_pkg::div_rsp_t rsp
);

  localparam int CW = $clog2(tes_pkg::QW + 1);

  logic                       busy_r;
  logic                       done_r;
  logic                       sat_r;
  logic [CW-1:0]              cnt_r;
  logic [tes_pkg::REMW-1:0]   rem_r;
  logic [tes_pkg::REMW-2:0]   ds_r;
  logic [tes_pkg::QW-1:0]     q_r;
  logic                       geq;

  assign geq = rem_r >= {1'b0, ds_r};

  assign rsp.done = done_r;
  assign rsp.sat  = sat_r;
  assign rsp.q    = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(tes_pkg::QW);
        rem_r  <= tes_pkg::REMW'(req.n);
        ds_r   <= {req.d, {(tes_pkg::QW-1){1'b0}}};
        q_r    <= '0;
        // The quotient does not fit in 47 bits when n >= d * 2^47.
        sat_r  <= tes_pkg::REMW'(req.n) >= {req.d, {tes_pkg::QW{1'b0}}};
      end else if (busy_r) begin
        if (geq) begin
          rem_r <= rem_r - {1'b0, ds_r};
        end
        q_r   <= {q_r[tes_pkg::QW-2:0], geq};
        ds_r  <= ds_r >> 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/tes_back.sv @@
`timescale 1ns / 1ps
// Compute engine: sequences gradients, determinant, volume and the 16 stiffness entries
// through a shared multiplier and divider, and holds the output register.
// Depends on tes_pkg, tes_mul and tes_div.
module tes_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  tes_pkg::edges_t                 q_rdata,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tes_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  output logic                            out_tuser
);

  localparam logic [tes_pkg::VW-1:0] VAL_MAX = {1'b0, {(tes_pkg::VW-1){1'b1}}};
  localparam logic [tes_pkg::VW-1:0] VAL_MIN = {1'b1, {(tes_pkg::VW-1){1'b0}}};
  localparam logic [tes_pkg::LW-1:0] LOAD_MAX = {tes_pkg::LW{1'b1}};

  tes_pkg::bk_state_t state_r, state_nxt;
  tes_pkg::ph_t       ph_r, ph_nxt;
  logic [1:0]         k_r, k_nxt;
  logic [1:0]         ax_r, ax_nxt;
  logic [1:0]         tm_r, tm_nxt;
  logic [3:0]         ent_r, ent_nxt;
  logic [3:0]         ld_r, ld_nxt;
  tes_pkg::edges_t    esh_r, esh_nxt;

  logic [tes_pkg::ACCW-1:0] acc_r, acc_nxt;
  logic [tes_pkg::ACCW-1:0] det_r;
  logic [tes_pkg::DW-1:0]   den_r;
  logic                     degen_r;
  logic [tes_pkg::LW-1:0]   load_r;
  logic                     eneg_r;
  logic [tes_pkg::VW-1:0]   val_r;

  logic                     out_valid_r;
  logic [1:0]               o_row_r;
  logic [1:0]               o_col_r;
  logic [tes_pkg::VW-1:0]   o_val_r;
  logic [tes_pkg::LW-1:0]   o_load_r;
  logic                     o_deg_r;
  logic                     o_last_r;

  logic [tes_pkg::OPW-1:0]  rf_mem [tes_pkg::RF_DEPTH];
  logic [tes_pkg::OPW-1:0]  rd_a_r;
  logic [tes_pkg::OPW-1:0]  rd_b_r;

  logic [tes_pkg::RF_AW-1:0] addr_a, addr_b, dest;
  logic                      b_one, neg, last_t;
  logic [1:0]                px, py, a1, a2;
  logic                      rf_we;
  logic [tes_pkg::RF_AW-1:0] rf_wa;
  logic [tes_pkg::OPW-1:0]   rf_wd;
  logic [tes_pkg::ACCW-1:0]  pext;
  logic [tes_pkg::ACCW-1:0]  term;
  logic [tes_pkg::ACCW-1:0]  adet;
  logic [tes_pkg::ACCW-1:0]  aacc;
  logic [tes_pkg::VW-1:0]    mag;
  logic                      emit;

  tes_pkg::mul_req_t mul_req;
  tes_pkg::mul_rsp_t mul_rsp;
  tes_pkg::div_req_t div_req;
  tes_pkg::div_rsp_t div_rsp;

  tes_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  tes_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // Operand selection for the current product term.
  always_comb begin
    case (k_r)
      2'd1:    begin px = 2'd1; py = 2'd2; end
      2'd2:    begin px = 2'd2; py = 2'd0; end
      default: begin px = 2'd0; py = 2'd1; end
    endcase
    case (ax_r)
      2'd0:    begin a1 = 2'd1; a2 = 2'd2; end
      2'd1:    begin a1 = 2'd2; a2 = 2'd0; end
      default: begin a1 = 2'd0; a2 = 2'd1; end
    endcase
    b_one  = 1'b0;
    neg    = 1'b0;
    last_t = (tm_r == 2'd2);
    dest   = tes_pkg::g_addr(k_r, ax_r);
    case (ph_r)
      tes_pkg::PH_CROSS: begin
        last_t = (tm_r == 2'd1);
        neg    = tm_r[0];
        addr_a = tes_pkg::e_addr(px, tm_r[0] ? a2 : a1);
        addr_b = tes_pkg::e_addr(py, tm_r[0] ? a1 : a2);
      end
      tes_pkg::PH_G1: begin
        neg    = 1'b1;
        b_one  = 1'b1;
        dest   = tes_pkg::g_addr(2'd0, ax_r);
        addr_a = tes_pkg::g_addr(tm_r + 2'd1, ax_r);
        addr_b = addr_a;
      end
      tes_pkg::PH_DET: begin
        addr_a = tes_pkg::e_addr(2'd0, tm_r);
        addr_b = tes_pkg::g_addr(2'd1, tm_r);
      end
      default: begin
        addr_a = tes_pkg::g_addr(ent_r[3:2], tm_r);
        addr_b = tes_pkg::g_addr(ent_r[1:0], tm_r);
      end
    endcase
  end

  assign pext = {{(tes_pkg::ACCW-tes_pkg::PW){mul_rsp.p[tes_pkg::PW-1]}}, mul_rsp.p};
  assign term = neg ? (~pext + 1'b1) : pext;
  assign adet = det_r[tes_pkg::ACCW-1] ? (~det_r + 1'b1) : det_r;
  assign aacc = acc_r[tes_pkg::ACCW-1] ? (~acc_r + 1'b1) : acc_r;

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[rf_wa] <= rf_wd;
    end
    rd_a_r <= rf_mem[addr_a];
    rd_b_r <= rf_mem[addr_b];
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    k_nxt     = k_r;
    ax_nxt    = ax_r;
    tm_nxt    = tm_r;
    ent_nxt   = ent_r;
    ld_nxt    = ld_r;
    esh_nxt   = esh_r;
    acc_nxt   = ((tm_r == 2'd0) ? '0 : acc_r) + term;
    q_pop     = 1'b0;
    rf_we     = 1'b0;
    rf_wa     = dest;
    rf_wd     = acc_nxt[tes_pkg::OPW-1:0];
    emit      = 1'b0;
    mag       = '0;
    mul_req.start = 1'b0;
    mul_req.a     = rd_a_r;
    mul_req.b     = b_one ? tes_pkg::OPW'(1) : rd_b_r;
    div_req.start = 1'b0;
    div_req.n     = aacc[tes_pkg::NW-1:0];
    div_req.d     = den_r;
    if (ph_r == tes_pkg::PH_DET) begin
      div_req.n = tes_pkg::NW'(adet >> (2*tes_pkg::COORD_FRAC_BITS));
      div_req.d = tes_pkg::DW'(6);
    end

    case (state_r)
      tes_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          esh_nxt   = q_rdata;
          ld_nxt    = '0;
          state_nxt = tes_pkg::BK_LOAD;
        end
      end
      tes_pkg::BK_LOAD: begin
        rf_we   = 1'b1;
        rf_wa   = tes_pkg::RF_AW'(ld_r);
        rf_wd   = {{(tes_pkg::OPW-tes_pkg::EW){esh_r[tes_pkg::EW-1]}},
                   esh_r[tes_pkg::EW-1:0]};
        esh_nxt = esh_r >> tes_pkg::EW;
        ld_nxt  = ld_r + 1'b1;
        if (ld_r == 4'(tes_pkg::N_EDGE - 1)) begin
          ph_nxt    = tes_pkg::PH_CROSS;
          k_nxt     = 2'd1;
          ax_nxt    = 2'd0;
          tm_nxt    = 2'd0;
          state_nxt = tes_pkg::BK_RD;
        end
      end
      tes_pkg::BK_RD: begin
        state_nxt = tes_pkg::BK_MS;
      end
      tes_pkg::BK_MS: begin
        mul_req.start = 1'b1;
        state_nxt     = tes_pkg::BK_MW;
      end
      tes_pkg::BK_MW: begin
        if (mul_rsp.done) begin
          if (!last_t) begin
            tm_nxt    = tm_r + 1'b1;
            state_nxt = tes_pkg::BK_RD;
          end else begin
            tm_nxt = 2'd0;
            case (ph_r)
              tes_pkg::PH_CROSS: begin
                rf_we     = 1'b1;
                state_nxt = tes_pkg::BK_RD;
                if (ax_r != 2'd2) begin
                  ax_nxt = ax_r + 1'b1;
                end else begin
                  ax_nxt = 2'd0;
                  if (k_r != 2'd3) begin
                    k_nxt = k_r + 1'b1;
                  end else begin
                    ph_nxt = tes_pkg::PH_G1;
                  end
                end
              end
              tes_pkg::PH_G1: begin
                rf_we     = 1'b1;
                state_nxt = tes_pkg::BK_RD;
                if (ax_r != 2'd2) begin
                  ax_nxt = ax_r + 1'b1;
                end else begin
                  ax_nxt = 2'd0;
                  ph_nxt = tes_pkg::PH_DET;
                end
              end
              default: begin
                state_nxt = tes_pkg::BK_DST;
              end
            endcase
          end
        end
      end
      tes_pkg::BK_DST: begin
        div_req.start = 1'b1;
        state_nxt     = tes_pkg::BK_DWT;
      end
      tes_pkg::BK_DWT: begin
        if (div_rsp.done) begin
          if (ph_r == tes_pkg::PH_DET) begin
            ph_nxt    = tes_pkg::PH_ENT;
            ent_nxt   = '0;
            state_nxt = degen_r ? tes_pkg::BK_EMIT : tes_pkg::BK_RD;
          end else begin
            state_nxt = tes_pkg::BK_EMIT;
          end
        end
      end
      tes_pkg::BK_EMIT: begin
        if (!out_valid_r || out_tready) begin
          emit    = 1'b1;
          ent_nxt = ent_r + 1'b1;
          if (ent_r == 4'hF) begin
            state_nxt = tes_pkg::BK_IDLE;
          end else begin
            state_nxt = degen_r ? tes_pkg::BK_EMIT : tes_pkg::BK_RD;
          end
        end
      end
      default: begin
        state_nxt = tes_pkg::BK_IDLE;
      end
    endcase

    // Entry value: -(dot)/den, so a positive dot gives a negative entry.
    if (div_rsp.sat) begin
      mag = eneg_r ? VAL_MIN : VAL_MAX;
    end else begin
      mag = {1'b0, div_rsp.q};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tes_pkg::BK_IDLE;
      ph_r        <= tes_pkg::PH_CROSS;
      k_r         <= 2'd1;
      ax_r        <= '0;
      tm_r        <= '0;
      ent_r       <= '0;
      ld_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      k_r     <= k_nxt;
      ax_r    <= ax_nxt;
      tm_r    <= tm_nxt;
      ent_r   <= ent_nxt;
      ld_r    <= ld_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    esh_r <= esh_nxt;
    if (state_r == tes_pkg::BK_MW && mul_rsp.done) begin
      acc_r <= acc_nxt;
      if (last_t && ph_r == tes_pkg::PH_DET) begin
        det_r <= acc_nxt;
      end
    end
    if (state_r == tes_pkg::BK_DST) begin
      if (ph_r == tes_pkg::PH_DET) begin
        den_r   <= (tes_pkg::DW'(adet) << 2) + (tes_pkg::DW'(adet) << 1);
        degen_r <= (det_r == '0);
      end else begin
        eneg_r <= !acc_r[tes_pkg::ACCW-1] && (acc_r != '0);
      end
    end
    if (state_r == tes_pkg::BK_DWT && div_rsp.done) begin
      if (ph_r == tes_pkg::PH_DET) begin
        load_r <= div_rsp.sat ? LOAD_MAX : div_rsp.q;
      end else begin
        val_r <= eneg_r ? (~mag + 1'b1) : mag;
      end
    end
    if (emit) begin
      o_row_r  <= ent_r[3:2];
      o_col_r  <= ent_r[1:0];
      o_val_r  <= degen_r ? '0 : val_r;
      o_load_r <= degen_r ? '0 : load_r;
      o_deg_r  <= degen_r;
      o_last_r <= (ent_r == 4'hF);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(tes_pkg::OUT_TDATA_W-tes_pkg::LW-tes_pkg::VW-4){1'b0}},
                       o_load_r, o_val_r, o_col_r, o_row_r};
  assign out_tlast  = o_last_r;
  assign out_tuser  = o_deg_r;

endmodule

@@ src/tetra_element_stiffness.sv @@
`timescale 1ns / 1ps
// Linear tetrahedron element stiffness. Per element: load the edge components, then
// run 78 product terms on the shared 70x70 multiplier and 17 passes through the
// divider, then emit the entries one at a time. A degenerate element skips the entry terms
// and their divisions. The two-entry edge queue accepts new elements while one is computed.
// Reset is synchronous, active low, and clears the sequencer, queue and handshake state.
module tetra_element_stiffness (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z, v4_x, v4_y, v4_z (32 bits each)
  input  logic [tes_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // local_row[1:0], local_col[3:2], stiffness_value[51:4], load_share[98:52], zero fill
  output logic [tes_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  // degenerate
  output logic                            out_tuser
);

  logic            q_full;
  logic            q_empty;
  logic            q_push;
  logic            q_pop;
  tes_pkg::edges_t q_wdata;
  tes_pkg::edges_t q_rdata;

  tes_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  tes_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  tes_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

@@ src/tes_sva.sv @@
`timescale 1ns / 1ps
// Port-level checks for the tetrahedron stiffness block, bound to the top level.
// Depends on tes_pkg and tetra_element_stiffness.
module tes_sva (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tes_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast,
  input logic                            out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[3:0] == 4'hF)))
    else $error("last flag not on the final entry");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[98:4] == '0)
    else $error("degenerate entry carries nonzero values");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind tetra_element_stiffness tes_sva u_sva (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

@@ verif/tetra_element_stiffness_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for tetra_element_stiffness: sends tetrahedral elements and checks all
// sixteen stiffness entries of each one against an exact wide-integer model. Needs tes_pkg.
module tetra_element_stiffness_test;

  typedef logic signed [191:0] wide_t;
  typedef logic [tes_pkg::IN_TDATA_W-1:0] elem_t;
  typedef struct {
    logic [1:0]  row;
    logic [1:0]  col;
    logic [47:0] value;
    logic [46:0] load;
    logic        degen;
    logic        last;
  } entry_t;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  elem_t in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [tes_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;
  logic out_tuser;

  elem_t  pending_elems[$];
  entry_t expected_entries[$];
  logic   in_taken = 1'b0;
  logic   calm = 1'b0;
  int     in_gap = 0;
  int     out_stall = 0;
  int     idle_cycles = 0;
  int     errors = 0;
  int     n_elems = 0;
  int     n_degen = 0;
  int     n_entries = 0;

  tetra_element_stiffness DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  always #4 clk = ~clk;

  function automatic wide_t dot3(input wide_t a0, a1, a2, b0, b1, b2);
    return a0 * b0 + a1 * b1 + a2 * b2;
  endfunction

  function automatic wide_t mag(input wide_t x);
    return (x < 0) ? -x : x;
  endfunction

  // Exact stiffness of one element; only the two final divisions round.
  task automatic predict_stiffness(input elem_t d);
    wide_t c[4][3];
    wide_t e[3][3];
    wide_t g[4][3];
    wide_t det, adet, den, dd, qm, lq;
    logic [46:0] load;
    logic [47:0] val;
    logic degen;
    entry_t ent;
    for (int v = 0; v < 4; v++)
      for (int a = 0; a < 3; a++)
        c[v][a] = $signed(d[32*(3*v+a) +: 32]);
    for (int v = 0; v < 3; v++)
      for (int a = 0; a < 3; a++)
        e[v][a] = c[v+1][a] - c[0][a];
    for (int k = 1; k < 4; k++) begin
      int p, q;
      p = (k == 1) ? 1 : (k == 2) ? 2 : 0;
      q = (k == 1) ? 2 : (k == 2) ? 0 : 1;
      g[k][0] = e[p][1] * e[q][2] - e[p][2] * e[q][1];
      g[k][1] = e[p][2] * e[q][0] - e[p][0] * e[q][2];
      g[k][2] = e[p][0] * e[q][1] - e[p][1] * e[q][0];
    end
    for (int a = 0; a < 3; a++)
      g[0][a] = -(g[1][a] + g[2][a] + g[3][a]);
    det = dot3(e[0][0], e[0][1], e[0][2], g[1][0], g[1][1], g[1][2]);
    degen = (det == 0);
    adet = mag(det);
    den = adet * 6;
    load = '0;
    if (!degen) begin
      lq = adet / (wide_t'(6) <<< (2 * tes_pkg::COORD_FRAC_BITS));
      load = (lq > wide_t'(47'h7FFF_FFFF_FFFF)) ? 47'h7FFF_FFFF_FFFF : lq[46:0];
    end
    n_elems++;
    if (degen) n_degen++;
    for (int k = 0; k < 16; k++) begin
      val = '0;
      if (!degen) begin
        dd = dot3(g[k>>2][0], g[k>>2][1], g[k>>2][2], g[k&3][0], g[k&3][1], g[k&3][2]);
        qm = mag(dd) / den;
        if (dd > 0) begin
          if (qm > (wide_t'(1) <<< 47)) qm = wide_t'(1) <<< 47;
          val = 48'd0 - qm[47:0];
        end else begin
          val = (qm > wide_t'(48'h7FFF_FFFF_FFFF)) ? 48'h7FFF_FFFF_FFFF : qm[47:0];
        end
      end
      ent.row = 2'(k >> 2);
      ent.col = 2'(k & 3);
      ent.value = val;
      ent.load = load;
      ent.degen = degen;
      ent.last = (k == 15);
      expected_entries.push_back(ent);
    end
  endtask

  function automatic elem_t pack_elem(input logic [31:0] w[12]);
    elem_t r;
    for (int i = 0; i < 12; i++) r[32*i +: 32] = w[i];
    return r;
  endfunction

  function automatic logic [31:0] rnd_coord(input int span);
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // A plausible element: a base point plus small random offsets.
  function automatic elem_t shaped_elem(input int span);
    logic [31:0] w[12];
    logic [31:0] base;
    for (int a = 0; a < 3; a++) begin
      base = ($urandom_range(0, 3) == 0) ? $urandom() : rnd_coord(span * 4);
      for (int v = 0; v < 4; v++) w[3*v+a] = base + rnd_coord(span);
    end
    return pack_elem(w);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_stiffness(in_tdata);
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 5);
        in_tvalid <= 1'b0;
      end else if (pending_elems.size() > 0) begin
        in_tdata <= pending_elems.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall = $urandom_range(0, 5);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    entry_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_entries++;
      if (expected_entries.size() == 0) begin
        $error("unexpected entry: tdata=%h", out_tdata);
        errors++;
      end else begin
        want = expected_entries.pop_front();
        if (out_tdata[1:0] !== want.row) begin
          $error("local_row: expected %0d, got %0d", want.row, out_tdata[1:0]);
          errors++;
        end
        if (out_tdata[3:2] !== want.col) begin
          $error("local_col: expected %0d, got %0d", want.col, out_tdata[3:2]);
          errors++;
        end
        if (out_tdata[51:4] !== want.value) begin
          $error("stiffness_value: expected %h, got %h", want.value, out_tdata[51:4]);
          errors++;
        end
        if (out_tdata[98:52] !== want.load) begin
          $error("load_share: expected %h, got %h", want.load, out_tdata[98:52]);
          errors++;
        end
        if (out_tuser !== want.degen) begin
          $error("degenerate: expected %0b, got %0b", want.degen, out_tuser);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last_entry: expected %0b, got %0b", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // Watchdog: fails the run if no element is taken and no entry is delivered within the idle limit.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [31:0] w[12];
    int sel;
    // Degenerate: all vertices at the origin.
    for (int i = 0; i < 12; i++) w[i] = 32'h0;
    pending_elems.push_back(pack_elem(w));
    // Unit right tetrahedron.
    w = '{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
    pending_elems.push_back(pack_elem(w));
    // Same with inverted orientation (negative determinant).
    w = '{0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0, 0, 0, 32'h10000};
    pending_elems.push_back(pack_elem(w));
    // Coplanar vertices, nonzero coordinates.
    w = '{32'h10000, 32'h20000, 0, 32'h30000, 32'h50000, 0,
          32'hFFFF0000, 32'h70000, 0, 32'h12345, 32'h54321, 0};
    pending_elems.push_back(pack_elem(w));
    // Collinear vertices.
    w = '{0, 0, 0, 32'h1, 32'h2, 32'h3, 32'h2, 32'h4, 32'h6, 32'h5, 32'hA, 32'hF};
    pending_elems.push_back(pack_elem(w));
    // Tiny volume: each edge is the smallest coordinate step, so the load share and the entries truncate to zero
    // while the element is still not degenerate.
    w = '{0, 0, 0, 32'h1, 0, 0, 0, 32'h1, 0, 0, 0, 32'h1};
    pending_elems.push_back(pack_elem(w));
    // Sliver element: tiny height over a large base.
    w = '{32'h80000000, 32'h80000000, 0, 32'h7FFFFFFF, 32'h80000000, 0,
          32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 32'h1};
    pending_elems.push_back(pack_elem(w));
    // Extreme coordinates, largest volume.
    w = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
          32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
          32'h80000000, 32'h80000000, 32'h7FFFFFFF};
    pending_elems.push_back(pack_elem(w));
    w = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
          32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
          32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000};
    pending_elems.push_back(pack_elem(w));
    for (int i = 0; i < 12; i++) w[i] = 32'hFFFFFFFF;
    pending_elems.push_back(pack_elem(w));
    for (int i = 0; i < 12; i++) w[i] = $urandom();
    pending_elems.push_back(pack_elem(w));
    for (int i = 0; i < 470; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 2) begin
        for (int j = 0; j < 12; j++) w[j] = $urandom();
        pending_elems.push_back(pack_elem(w));
      end else if (sel < 3) begin
        pending_elems.push_back(shaped_elem(4));
      end else if (sel < 4) begin
        // Flattened element: vertex 4 on the plane through the first three.
        for (int j = 0; j < 9; j++) w[j] = rnd_coord(1 << 20);
        for (int a = 0; a < 3; a++) w[9+a] = w[3+a] + w[6+a] - w[a];
        pending_elems.push_back(pack_elem(w));
      end else begin
        pending_elems.push_back(shaped_elem(1 << $urandom_range(8, 24)));
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (pending_elems.size() < 40);
    calm = 1'b1;
    while (pending_elems.size() > 0 || in_tvalid || expected_entries.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d elements (%0d degenerate), %0d stiffness entries checked.",
             n_elems, n_degen, n_entries);
    if (errors == 0 && expected_entries.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ tetra_element_stiffness.f @@
src/tes_pkg.sv
src/tes_front.sv
src/tes_queue.sv
src/tes_mul.sv
src/tes_div.sv
src/tes_back.sv
src/tetra_element_stiffness.sv
src/tes_sva.sv
verif/tetra_element_stiffness_test.sv
